// ===== hw/rtl/selective_repeat_arq_sender_macros.svh =====
// Assertion macros used by the ARQ sender back end (sra_back).
`ifndef SELECTIVE_REPEAT_ARQ_SENDER_MACROS_SVH
`define SELECTIVE_REPEAT_ARQ_SENDER_MACROS_SVH
`ifndef SYNTHESIS
`define SRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SRA_ASSERT(lbl, prop, msg)
`define SRA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sra_pkg.sv =====
// Types, codes and constants of the selective-repeat ARQ sender.
package sra_pkg;
    localparam int MAX_SEQ_BITS     = 7;
    localparam int FRAME_COUNT_BITS = 24;
    localparam int TIMER_BITS       = 16;
    localparam int NSLOTS           = 1 << MAX_SEQ_BITS;
    localparam int WALK_LIMIT       = 1 << (MAX_SEQ_BITS - 1);

    typedef logic [MAX_SEQ_BITS-1:0]     seq_t;
    typedef logic [FRAME_COUNT_BITS-1:0] frame_t;
    typedef logic [TIMER_BITS-1:0]       timer_t;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_CTRL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] CFG_SEQ_BITS     = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd1;
    localparam logic [1:0] CFG_TOTAL_FRAMES = 2'd2;

    typedef enum logic [2:0] {
        ACT_NEW     = 3'd0,
        ACT_RETX    = 3'd1,
        ACT_CORRUPT = 3'd2,
        ACT_OOW     = 3'd3,
        ACT_ACK     = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CMD_SEND,
        CMD_CORRUPT,
        CMD_CTRL,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        seq_t      seq;
        logic      is_nak;
    } cmd_t;

    typedef struct packed {
        logic [2:0] seq_bits;
        timer_t     timeout;
        frame_t     total;
    } cfg_t;

    typedef struct packed {
        action_t action;
        frame_t  frame;
        seq_t    seq;
        seq_t    base;
        logic    done;
        logic    last;
    } result_t;
endpackage

// ===== hw/rtl/sra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/sra_front.sv =====
// Input side: decodes each transaction into a command and queues it; an unknown operation is dropped.
module sra_front
    import sra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_op,
    input  seq_t       in_seq,
    input  logic       in_nak,
    input  logic       in_crc,
    output logic       q_valid,
    input  logic       q_pop,
    output cmd_t       q_cmd
);
    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.seq    = in_seq;
        cmd_in.is_nak = in_nak;
        unique case (in_op)
            OP_SEND: cmd_in.kind = CMD_SEND;
            OP_CTRL: cmd_in.kind = in_crc ? CMD_CTRL : CMD_CORRUPT;
            OP_TICK: cmd_in.kind = CMD_TICK;
            default: cmd_in.kind = CMD_TICK;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    // an unknown operation is taken and dropped here
    assign push     = in_valid && in_ready && (in_op != 2'd3);
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== hw/rtl/sra_back.sv =====
// Execution side: window state, slot timers and result sequencing.
`include "selective_repeat_arq_sender_macros.svh"
module sra_back
    import sra_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_pop,
    input  cmd_t    q_cmd,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ACK_MARK,
        S_SLIDE,
        S_ACK_OUT,
        S_NAK_OUT,
        S_TICK_RD,
        S_TICK_EVAL,
        S_TICK_FLUSH
    } state_t;

    localparam logic [MAX_SEQ_BITS:0] ONE = (MAX_SEQ_BITS+1)'(1);

    state_t            st_reg, st_next;
    seq_t              base_reg, base_next;
    seq_t              nseq_reg, nseq_next;
    frame_t            nframe_reg, nframe_next;
    logic [NSLOTS-1:0] acked_reg, acked_next;
    logic [NSLOTS-1:0] ton_reg, ton_next;
    cmd_t              cmd_reg, cmd_next;
    seq_t              idx_reg, idx_next;
    seq_t              visited_reg, visited_next;
    logic              pend_valid_reg, pend_valid_next;
    frame_t            pend_frame_reg, pend_frame_next;
    seq_t              pend_seq_reg, pend_seq_next;
    frame_t            fr_reg, fr_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic [2:0] m_eff;
    seq_t       mask;
    seq_t       sw;
    timer_t     reload;
    logic       can_load;
    logic       done_now;
    seq_t       occ;
    logic       oow;
    logic       slide_go;
    seq_t       base_inc;

    logic   fram_we, fram_re, tram_we, tram_re;
    seq_t   fram_waddr, fram_raddr, tram_waddr;
    frame_t fram_wdata, fram_rdata;
    timer_t tram_wdata, tram_rdata;

    sra_ram #(.WIDTH(FRAME_COUNT_BITS), .DEPTH(NSLOTS)) u_frame_ram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (fram_waddr),
        .wdata (fram_wdata),
        .re    (fram_re),
        .raddr (fram_raddr),
        .rdata (fram_rdata)
    );

    sra_ram #(.WIDTH(TIMER_BITS), .DEPTH(NSLOTS)) u_timer_ram (
        .clk   (clk),
        .we    (tram_we),
        .waddr (tram_waddr),
        .wdata (tram_wdata),
        .re    (tram_re),
        .raddr (idx_reg),
        .rdata (tram_rdata)
    );

    always_comb
    begin
        if (cfg.seq_bits < 3'd2)
            m_eff = 3'd2;
        else if (cfg.seq_bits > 3'(MAX_SEQ_BITS))
            m_eff = 3'(MAX_SEQ_BITS);
        else
            m_eff = cfg.seq_bits;
    end

    assign mask     = seq_t'((ONE << m_eff) - ONE);
    assign sw       = seq_t'(ONE << (m_eff - 3'd1));
    assign reload   = (cfg.timeout == '0) ? timer_t'(1) : cfg.timeout;
    assign can_load = !out_valid_reg || out_ready;
    assign done_now = (nframe_reg >= cfg.total) && (base_reg == nseq_reg);
    assign occ      = (nseq_reg - base_reg) & mask;
    assign oow      = (cmd_reg.seq > mask) || (((cmd_reg.seq - base_reg) & mask) >= occ);
    assign slide_go = (base_reg != nseq_reg) && acked_reg[base_reg];
    assign base_inc = (base_reg + seq_t'(1)) & mask;

    always_comb
    begin
        st_next         = st_reg;
        base_next       = base_reg;
        nseq_next       = nseq_reg;
        nframe_next     = nframe_reg;
        acked_next      = acked_reg;
        ton_next        = ton_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        visited_next    = visited_reg;
        pend_valid_next = pend_valid_reg;
        pend_frame_next = pend_frame_reg;
        pend_seq_next   = pend_seq_reg;
        fr_next         = fr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        fram_we         = 1'b0;
        fram_re         = 1'b0;
        fram_waddr      = nseq_reg;
        fram_wdata      = nframe_reg;
        fram_raddr      = cmd_reg.seq;
        tram_we         = 1'b0;
        tram_re         = 1'b0;
        tram_waddr      = idx_reg;
        tram_wdata      = reload;

        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    base_next = base_reg & mask;
                    nseq_next = nseq_reg & mask;
                    st_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (cmd_reg.kind)
                    CMD_SEND:
                    begin
                        if (!(occ < sw && nframe_reg < cfg.total))
                        begin
                            st_next = S_IDLE;
                        end
                        else if (can_load)
                        begin
                            fram_we              = 1'b1;
                            tram_we              = 1'b1;
                            tram_waddr           = nseq_reg;
                            acked_next[nseq_reg] = 1'b0;
                            ton_next[nseq_reg]   = 1'b1;
                            out_valid_next       = 1'b1;
                            out_next.action      = ACT_NEW;
                            out_next.frame       = nframe_reg;
                            out_next.seq         = nseq_reg;
                            out_next.base        = base_reg;
                            out_next.done        =
                                ({1'b0, nframe_reg} + 25'd1 >= {1'b0, cfg.total}) &&
                                (base_reg == ((nseq_reg + seq_t'(1)) & mask));
                            out_next.last        = 1'b1;
                            nframe_next          = nframe_reg + frame_t'(1);
                            nseq_next            = (nseq_reg + seq_t'(1)) & mask;
                            st_next              = S_IDLE;
                        end
                    end
                    CMD_CORRUPT, CMD_CTRL:
                    begin
                        if (cmd_reg.kind == CMD_CORRUPT || oow)
                        begin
                            if (can_load)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.action = (cmd_reg.kind == CMD_CORRUPT) ?
                                                  ACT_CORRUPT : ACT_OOW;
                                out_next.frame  = '0;
                                out_next.seq    = cmd_reg.seq;
                                out_next.base   = base_reg;
                                out_next.done   = done_now;
                                out_next.last   = 1'b1;
                                st_next         = S_IDLE;
                            end
                        end
                        else
                        begin
                            fram_re = 1'b1;
                            st_next = cmd_reg.is_nak ? S_NAK_OUT : S_ACK_MARK;
                        end
                    end
                    CMD_TICK:
                    begin
                        idx_next     = base_reg;
                        visited_next = '0;
                        st_next      = S_TICK_RD;
                    end
                endcase
            end
            S_ACK_MARK:
            begin
                fr_next                 = fram_rdata;
                acked_next[cmd_reg.seq] = 1'b1;
                ton_next[cmd_reg.seq]   = 1'b0;
                st_next                 = S_SLIDE;
            end
            S_SLIDE:
            begin
                if (slide_go)
                begin
                    acked_next[base_reg] = 1'b0;
                    ton_next[base_reg]   = 1'b0;
                    base_next            = base_inc;
                end
                else
                begin
                    st_next = S_ACK_OUT;
                end
            end
            S_ACK_OUT:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_next.action = ACT_ACK;
                    out_next.frame  = fr_reg;
                    out_next.seq    = cmd_reg.seq;
                    out_next.base   = base_reg;
                    out_next.done   = done_now;
                    out_next.last   = 1'b1;
                    st_next         = S_IDLE;
                end
            end
            S_NAK_OUT:
            begin
                if (can_load)
                begin
                    tram_we               = 1'b1;
                    tram_waddr            = cmd_reg.seq;
                    ton_next[cmd_reg.seq] = 1'b1;
                    out_valid_next        = 1'b1;
                    out_next.action       = ACT_RETX;
                    out_next.frame        = fram_rdata;
                    out_next.seq          = cmd_reg.seq;
                    out_next.base         = base_reg;
                    out_next.done         = done_now;
                    out_next.last         = 1'b1;
                    st_next               = S_IDLE;
                end
            end
            S_TICK_RD:
            begin
                if (idx_reg == nseq_reg || visited_reg == seq_t'(WALK_LIMIT))
                begin
                    st_next = S_TICK_FLUSH;
                end
                else
                begin
                    fram_re    = 1'b1;
                    fram_raddr = idx_reg;
                    tram_re    = 1'b1;
                    st_next    = S_TICK_EVAL;
                end
            end
            S_TICK_EVAL:
            begin
                // expiries are held back one step so the final one can carry last
                if (!ton_reg[idx_reg])
                begin
                    idx_next     = (idx_reg + seq_t'(1)) & mask;
                    visited_next = visited_reg + seq_t'(1);
                    st_next      = S_TICK_RD;
                end
                else if (tram_rdata > timer_t'(1))
                begin
                    tram_we      = 1'b1;
                    tram_wdata   = tram_rdata - timer_t'(1);
                    idx_next     = (idx_reg + seq_t'(1)) & mask;
                    visited_next = visited_reg + seq_t'(1);
                    st_next      = S_TICK_RD;
                end
                else if (!pend_valid_reg || can_load)
                begin
                    tram_we = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_next.action = ACT_RETX;
                        out_next.frame  = pend_frame_reg;
                        out_next.seq    = pend_seq_reg;
                        out_next.base   = base_reg;
                        out_next.done   = done_now;
                        out_next.last   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_frame_next = fram_rdata;
                    pend_seq_next   = idx_reg;
                    idx_next        = (idx_reg + seq_t'(1)) & mask;
                    visited_next    = visited_reg + seq_t'(1);
                    st_next         = S_TICK_RD;
                end
            end
            S_TICK_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    st_next = S_IDLE;
                end
                else if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_next.action = ACT_RETX;
                    out_next.frame  = pend_frame_reg;
                    out_next.seq    = pend_seq_reg;
                    out_next.base   = base_reg;
                    out_next.done   = done_now;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    st_next         = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_IDLE;
            base_reg       <= '0;
            nseq_reg       <= '0;
            nframe_reg     <= '0;
            acked_reg      <= '0;
            ton_reg        <= '0;
            cmd_reg        <= '0;
            idx_reg        <= '0;
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_frame_reg <= '0;
            pend_seq_reg   <= '0;
            fr_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            st_reg         <= st_next;
            base_reg       <= base_next;
            nseq_reg       <= nseq_next;
            nframe_reg     <= nframe_next;
            acked_reg      <= acked_next;
            ton_reg        <= ton_next;
            cmd_reg        <= cmd_next;
            idx_reg        <= idx_next;
            visited_reg    <= visited_next;
            pend_valid_reg <= pend_valid_next;
            pend_frame_reg <= pend_frame_next;
            pend_seq_reg   <= pend_seq_next;
            fr_reg         <= fr_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    `SRA_ASSERT(a_pend_in_tick, !pend_valid_reg || st_reg == S_TICK_RD || st_reg == S_TICK_EVAL || st_reg == S_TICK_FLUSH, "held retransmit outside a tick walk")
    `SRA_ASSERT(a_walk_bound, visited_reg <= seq_t'(WALK_LIMIT), "tick walk exceeded its slot limit")
    `SRA_ASSERT_NEXT(a_slide_step, st_reg == S_SLIDE && slide_go, base_reg == $past(base_inc), "window base did not advance over an acknowledged slot")
endmodule

// ===== hw/rtl/selective_repeat_arq_sender.sv =====
// Selective-repeat ARQ sender. One transaction is executed at a time.
// Send, corrupt and out-of-window results are loaded in the dispatch state; a NAK reads the frame RAM first.
// An ACK reads the frame RAM, marks the slot, then slides the base over each acknowledged slot.
// A tick walks up to 64 slots from the base, reading and then evaluating each slot's timer.
// A two-entry command queue takes transactions while the back end works or stalls.
// rst_n (async, active low) clears window state; slot RAMs are not cleared.
module selective_repeat_arq_sender
    import sra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ctrl_seq[6:0], ctrl_crc_ok[7]
    input  logic [2:0]  s_axis_tuser,   // operation[1:0], ctrl_is_nak[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // frame_number[23:0], seq_out[30:24],
                                        // window_base[37:31], all_done[38], zero[39]
    output logic [2:0]  m_axis_tuser,   // action[2:0]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    cfg_t    cfg_reg;
    logic    q_valid;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seq_bits <= 3'd3;
            cfg_reg.timeout  <= timer_t'(100);
            cfg_reg.total    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEQ_BITS:     cfg_reg.seq_bits <= cfg_data[2:0];
                CFG_TIMEOUT:      cfg_reg.timeout  <= cfg_data[TIMER_BITS-1:0];
                CFG_TOTAL_FRAMES: cfg_reg.total    <= cfg_data[FRAME_COUNT_BITS-1:0];
                default:          cfg_reg          <= cfg_reg;
            endcase
        end
    end

    sra_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser[1:0]),
        .in_seq   (s_axis_tdata[6:0]),
        .in_nak   (s_axis_tuser[2]),
        .in_crc   (s_axis_tdata[7]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    sra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {1'b0, res.done, res.base, res.seq, res.frame};
    assign m_axis_tuser = res.action;
    assign m_axis_tlast = res.last;
endmodule
